/* src/nlb_pkg.sv */
// Shared types, codes and byte helpers for the newline line buffer.
package nlb_pkg;

   // Request opcodes
   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_NO_LINE  = 2'd2;
   localparam logic [1:0] ST_TOO_LONG = 2'd3;

   // Byte constants
   localparam logic [7:0] NL_BYTE = 8'h0A;

   // Output limit register
   localparam int          LIMIT_W     = 7;
   localparam logic [6:0] LIMIT_MAX   = 7'd65;
   localparam logic [6:0] LIMIT_RESET = 7'd65;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic       chunk_last;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       append;
      logic       scan_start;
      logic       scan;
      logic       emit_start;
      logic       emit;
      logic       put_result;
      logic [1:0] result_code;
      logic       emit_byte;
      logic       commit;
   } nlb_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic nl_hit;
      logic too_long;
      logic keep_zero;
      logic scan_end;
      logic byte_ready;
      logic emit_last;
   } nlb_stat_type;

   // Space, tab, newline, vertical tab, form feed, carriage return
   function automatic logic is_ws(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

endpackage

/* src/nlb_ram.sv */
// Generic simple dual-port RAM with registered read.
module nlb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/nlb_ctrl.sv */
// Sequencing state machine for append, line scan and line emission.
module nlb_ctrl
   import nlb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_command,
   input  nlb_stat_type stat,
   output nlb_cmd_type  cmd,
   output logic         busy
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_command == OP_APPEND) begin
                  cmd.append = 1'b1;
               end else begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.nl_hit) begin
               if (stat.too_long) begin
                  cmd.put_result  = 1'b1;
                  cmd.result_code = ST_TOO_LONG;
                  state_in        = S_IDLE;
               end else if (stat.keep_zero) begin
                  // whole line is whitespace: one empty result
                  cmd.put_result  = 1'b1;
                  cmd.result_code = ST_OK;
                  cmd.commit      = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  cmd.emit_start = 1'b1;
                  state_in       = S_EMIT;
               end
            end else if (stat.scan_end) begin
               cmd.put_result  = 1'b1;
               cmd.result_code = ST_NO_LINE;
               state_in        = S_IDLE;
            end
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            if (stat.byte_ready) begin
               cmd.emit_byte = 1'b1;
               if (stat.emit_last) begin
                  cmd.commit = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* src/nlb_dp.sv */
// Datapath: circular byte store, counters, scan/emit read pipeline, result register.
module nlb_dp
   import nlb_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  nlb_cmd_type        cmd,
   input  req_type            req_payload,
   input  logic               csr_valid,
   input  logic [LIMIT_W-1:0] csr_data,
   output nlb_stat_type       stat,
   output logic               rsp_strobe,
   output rsp_type            rsp_payload
);

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int SW   = CW + 1;
   localparam int CMPW = CW + 8;

   // Sum of a position below CAPACITY and an offset up to CAPACITY, folded back into range
   function automatic logic [AW-1:0] wrap_pos(input logic [SW-1:0] s);
      logic [SW-1:0] t;
      t = (s >= SW'(CAPACITY)) ? s - SW'(CAPACITY) : s;
      return t[AW-1:0];
   endfunction

   logic [AW-1:0]      head_ff,     head_in;
   logic [CW-1:0]      stored_ff,   stored_in;
   logic [CW-1:0]      staged_ff,   staged_in;
   logic               overflow_ff, overflow_in;
   logic [LIMIT_W-1:0] limit_ff,    limit_in;
   logic [CW-1:0]      rd_idx_ff,   rd_idx_in;
   logic               rd_vld_ff,   rd_vld_in;
   logic [CW-1:0]      rd_tag_ff,   rd_tag_in;
   logic [CW-1:0]      keep_ff,     keep_in;
   logic [CW-1:0]      len_ff,      len_in;
   logic               strobe_ff,   strobe_in;
   rsp_type            rsp_ff,      rsp_in;

   logic [CW-1:0]      fill;
   logic               room;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [7:0]         ram_q;
   logic [CW-1:0]      issue_lim;
   logic               issue;
   logic [CW-1:0]      len_now;
   logic [CW-1:0]      len_use;
   logic [LIMIT_W-1:0] limit_eff;

   // Byte store
   nlb_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.data_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Append write position behind committed and staged bytes
   assign fill    = stored_ff + staged_ff;
   assign room    = (fill < CW'(CAPACITY));
   assign wr_en   = cmd.append && room;
   assign wr_addr = wrap_pos(SW'(head_ff) + SW'(fill));

   // Read issue for scan and emit passes
   assign issue_lim = cmd.emit ? keep_ff : stored_ff;
   assign issue     = (cmd.scan || cmd.emit) && (rd_idx_ff < issue_lim);
   assign rd_addr   = wrap_pos(SW'(head_ff) + SW'(rd_idx_ff));

   assign len_now   = rd_tag_ff + CW'(1);
   assign limit_eff = (limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff;

   // Status to controller
   always_comb begin
      stat.nl_hit     = rd_vld_ff && (ram_q == NL_BYTE);
      stat.too_long   = (CMPW'(rd_tag_ff) + CMPW'(2)) > CMPW'(limit_eff);
      stat.keep_zero  = (keep_ff == '0);
      stat.scan_end   = !rd_vld_ff && (rd_idx_ff == stored_ff);
      stat.byte_ready = rd_vld_ff;
      stat.emit_last  = rd_vld_ff && (len_now == keep_ff);
   end

   // Length of the line being removed
   assign len_use = (cmd.scan && stat.nl_hit) ? len_now : len_ff;

   // Next-state logic
   always_comb begin
      head_in     = head_ff;
      stored_in   = stored_ff;
      staged_in   = staged_ff;
      overflow_in = overflow_ff;
      limit_in    = limit_ff;
      rd_idx_in   = issue ? rd_idx_ff + CW'(1) : rd_idx_ff;
      rd_vld_in   = issue;
      rd_tag_in   = rd_idx_ff;
      keep_in     = keep_ff;
      len_in      = len_ff;
      strobe_in   = 1'b0;
      rsp_in      = rsp_ff;

      if (csr_valid) begin
         limit_in = csr_data;
      end

      // Append: stage the byte, settle the chunk on its last byte
      if (cmd.append) begin
         if (room) begin
            staged_in = staged_ff + CW'(1);
         end else begin
            overflow_in = 1'b1;
         end
         if (req_payload.chunk_last) begin
            strobe_in         = 1'b1;
            rsp_in.out_byte   = '0;
            rsp_in.byte_valid = 1'b0;
            rsp_in.last       = 1'b1;
            if (overflow_ff || !room) begin
               rsp_in.status = ST_FULL;
            end else begin
               rsp_in.status = ST_OK;
               stored_in     = stored_ff + staged_ff + CW'(1);
            end
            staged_in   = '0;
            overflow_in = 1'b0;
         end
      end

      // Scan: track the last non-whitespace byte and the newline position
      if (cmd.scan && rd_vld_ff) begin
         if (!is_ws(ram_q)) begin
            keep_in = len_now;
         end
         if (stat.nl_hit) begin
            len_in = len_now;
         end
      end

      if (cmd.scan_start) begin
         rd_idx_in = '0;
         rd_vld_in = 1'b0;
         keep_in   = '0;
      end
      if (cmd.emit_start) begin
         rd_idx_in = '0;
         rd_vld_in = 1'b0;
      end

      // Single-result outcomes
      if (cmd.put_result) begin
         strobe_in         = 1'b1;
         rsp_in.status     = cmd.result_code;
         rsp_in.out_byte   = '0;
         rsp_in.byte_valid = 1'b0;
         rsp_in.last       = 1'b1;
      end

      // Line bytes
      if (cmd.emit_byte) begin
         strobe_in         = 1'b1;
         rsp_in.status     = ST_OK;
         rsp_in.out_byte   = ram_q;
         rsp_in.byte_valid = 1'b1;
         rsp_in.last       = stat.emit_last;
      end

      // Remove the line from the store
      if (cmd.commit) begin
         head_in   = wrap_pos(SW'(head_ff) + SW'(len_use));
         stored_in = stored_ff - len_use;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         stored_ff   <= '0;
         staged_ff   <= '0;
         overflow_ff <= 1'b0;
         limit_ff    <= LIMIT_RESET;
         rd_idx_ff   <= '0;
         rd_vld_ff   <= 1'b0;
         keep_ff     <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         head_ff     <= head_in;
         stored_ff   <= stored_in;
         staged_ff   <= staged_in;
         overflow_ff <= overflow_in;
         limit_ff    <= limit_in;
         rd_idx_ff   <= rd_idx_in;
         rd_vld_ff   <= rd_vld_in;
         keep_ff     <= keep_in;
         strobe_ff   <= strobe_in;
      end
      rd_tag_ff <= rd_tag_in;
      len_ff    <= len_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* src/newline_line_buffer.sv */
// Top level of the newline-delimited line buffer.
//
// A transaction is taken when start is high and busy is low. An append never
// raises busy; the byte marked chunk_last yields one result in the following
// cycle. A pop walks the circular store through the RAM's registered read port,
// one byte per cycle: once the scan reaches a line's newline, its kept bytes
// stream out one per cycle, read through the same port. When the store holds no
// newline the scan covers every committed byte. Each result appears on rsp_payload
// for exactly one cycle with rsp_strobe high, one register after the decision; the
// receiver must take it then. The output limit register is written through
// csr_valid/csr_ready and should only be changed while the block is idle.
module newline_line_buffer
   import nlb_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_payload,
   output logic               rsp_strobe,
   output rsp_type            rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_data
);

   nlb_cmd_type  cmd;
   nlb_stat_type stat;
   logic         csr_wr;

   // Register port always accepts
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   nlb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_payload.command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy)
   );

   nlb_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .csr_valid   (csr_wr),
      .csr_data    (csr_data),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule
